>>> rtl/dcd_pkg.sv
// Shared types and constants for the directed cycle detector.
package dcd_pkg;

    localparam int FIELD_W          = 11;
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;
    localparam logic [FIELD_W-1:0] VCOUNT_RESET = 11'd1;

    typedef enum logic [1:0] {
        COL_WHITE = 2'd0,
        COL_GREY  = 2'd1,
        COL_BLACK = 2'd2
    } color_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_LOAD,
        S_DRAIN,
        S_SCAN,
        S_SCAN_CHK,
        S_STEP,
        S_POP,
        S_EDGE,
        S_VISIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic hd_re;
        logic hd_we;
        logic col_re;
        logic col_we;
        logic edg_re;
        logic edg_we;
        logic stk_re;
        logic stk_we;
    } mem_ctl_t;

endpackage

>>> rtl/dcd_if.sv
// Handshake channel interfaces: edge requests, results and configuration writes.
interface dcd_edge_if;
    logic                        valid;
    logic                        ready;
    logic [dcd_pkg::FIELD_W-1:0] edge_from;
    logic [dcd_pkg::FIELD_W-1:0] edge_to;
    logic                        edge_present;
    logic                        last_edge;

    modport source (output valid, edge_from, edge_to, edge_present, last_edge, input ready);
    modport sink   (input valid, edge_from, edge_to, edge_present, last_edge, output ready);
endinterface

interface dcd_result_if;
    logic valid;
    logic ready;
    logic has_cycle;
    logic edges_dropped;

    modport source (output valid, has_cycle, edges_dropped, input ready);
    modport sink   (input valid, has_cycle, edges_dropped, output ready);
endinterface

interface dcd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dcd_pkg::FIELD_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

>>> rtl/dcd_graph_mem.sv
// Graph storage: list heads, colors, edge records and the search stack.
module dcd_graph_mem #(
    parameter int MAX_VERTICES = dcd_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = dcd_pkg::DEF_MAX_EDGES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dcd_pkg::mem_ctl_t                   ctl,
    input  logic [$clog2(MAX_VERTICES)-1:0]     hd_raddr,
    input  logic [$clog2(MAX_VERTICES)-1:0]     hd_waddr,
    input  logic [$clog2(MAX_EDGES):0]          hd_wdata,
    output logic [$clog2(MAX_EDGES):0]          hd_rdata,
    input  logic [$clog2(MAX_VERTICES)-1:0]     col_raddr,
    input  logic [$clog2(MAX_VERTICES)-1:0]     col_waddr,
    input  dcd_pkg::color_t                     col_wdata,
    output dcd_pkg::color_t                     col_rdata,
    input  logic [$clog2(MAX_EDGES)-1:0]        edg_raddr,
    input  logic [$clog2(MAX_EDGES)-1:0]        edg_waddr,
    input  logic [$clog2(MAX_VERTICES)-1:0]     edg_wtgt,
    input  logic [$clog2(MAX_EDGES):0]          edg_wnext,
    output logic [$clog2(MAX_VERTICES)-1:0]     edg_rtgt,
    output logic [$clog2(MAX_EDGES):0]          edg_rnext,
    input  logic [$clog2(MAX_VERTICES)-1:0]     stk_raddr,
    input  logic [$clog2(MAX_VERTICES)-1:0]     stk_waddr,
    input  logic [$clog2(MAX_VERTICES)-1:0]     stk_wvert,
    input  logic [$clog2(MAX_EDGES):0]          stk_wedge,
    output logic [$clog2(MAX_VERTICES)-1:0]     stk_rvert,
    output logic [$clog2(MAX_EDGES):0]          stk_redge
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int EW  = EAW + 1;

    logic [EW-1:0]      head_mem  [MAX_VERTICES];
    dcd_pkg::color_t    color_mem [MAX_VERTICES];
    logic [VW+EW-1:0]   edge_mem  [MAX_EDGES];
    logic [VW+EW-1:0]   stack_mem [MAX_VERTICES];

    logic [EW-1:0]      head_rd_reg;
    logic [VW-1:0]      hd_raddr_reg;
    logic               fwd_valid_reg;
    logic [VW-1:0]      fwd_addr_reg;
    logic [EW-1:0]      fwd_data_reg;
    dcd_pkg::color_t    color_rd_reg;
    logic [VW+EW-1:0]   edge_rd_reg;
    logic [VW+EW-1:0]   stack_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.hd_re)
        begin
            head_rd_reg  <= head_mem[hd_raddr];
            hd_raddr_reg <= hd_raddr;
        end
        if (ctl.hd_we)
        begin
            head_mem[hd_waddr] <= hd_wdata;
            fwd_addr_reg       <= hd_waddr;
            fwd_data_reg       <= hd_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (ctl.hd_we)
            fwd_valid_reg <= 1'b1;
    end

    // back-to-back edges from one vertex: the read raced the previous head write
    assign hd_rdata = (fwd_valid_reg && fwd_addr_reg == hd_raddr_reg) ? fwd_data_reg
                                                                     : head_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.col_re)
            color_rd_reg <= color_mem[col_raddr];
        if (ctl.col_we)
            color_mem[col_waddr] <= col_wdata;
    end

    assign col_rdata = color_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.edg_re)
            edge_rd_reg <= edge_mem[edg_raddr];
        if (ctl.edg_we)
            edge_mem[edg_waddr] <= {edg_wtgt, edg_wnext};
    end

    assign edg_rtgt  = edge_rd_reg[VW+EW-1:EW];
    assign edg_rnext = edge_rd_reg[EW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.stk_re)
            stack_rd_reg <= stack_mem[stk_raddr];
        if (ctl.stk_we)
            stack_mem[stk_waddr] <= {stk_wvert, stk_wedge};
    end

    assign stk_rvert = stack_rd_reg[VW+EW-1:EW];
    assign stk_redge = stack_rd_reg[EW-1:0];

endmodule

>>> rtl/directed_cycle_detector_core.sv
// Directed cycle detector: edge loader, depth-first search sequencer and result register.
//
// Channels: cfg writes vertex_count (any time the block is idle, always ready).
// edges carries one directed edge per request, vertices numbered from one.
// result carries one response per graph, after the request marked last_edge.
//
// Loading: one edge request per cycle. Each edge is linked onto its source
// vertex's list with a head read and a write in the cycle after it.
// Search: after the last request, a drain state, then scan and check states per start
// vertex examined, step, edge and visit states per edge followed, step and pop per backtrack.
// Edges out of range, or beyond MAX_EDGES stored, are dropped and flagged.
// After each response is registered, a clearing pass over all MAX_VERTICES entries
// resets list heads and colors; edges is not ready during it.
// Reset: vertex_count returns to 1 and the same clearing pass runs first.
// Stall: the result register holds until taken; the next graph may load
// meanwhile, and its search waits before writing the result register.
module directed_cycle_detector_core #(
    parameter int MAX_VERTICES = dcd_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = dcd_pkg::DEF_MAX_EDGES
) (
    input  logic        clk,
    input  logic        rst_n,
    dcd_cfg_if.sink     cfg,
    dcd_edge_if.sink    edges,
    dcd_result_if.source result
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int DW  = VW + 1;
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int EW  = EAW + 1;
    localparam int NW  = (VW + 1 > dcd_pkg::FIELD_W) ? VW + 1 : dcd_pkg::FIELD_W;
    localparam logic [EW-1:0] EMPTY = EW'(MAX_EDGES);

    dcd_pkg::state_t            state_reg, state_next;
    logic [dcd_pkg::FIELD_W-1:0] vcount_reg;
    logic [EW-1:0]              ecnt_reg, ecnt_next;
    logic                       drop_reg, drop_next;
    logic                       found_reg, found_next;
    logic [VW-1:0]              scan_v_reg, scan_v_next;
    logic [VW-1:0]              cur_v_reg, cur_v_next;
    logic [EW-1:0]              cur_e_reg, cur_e_next;
    logic [VW-1:0]              w_reg, w_next;
    logic [DW-1:0]              depth_reg, depth_next;
    logic [VW-1:0]              clr_idx_reg, clr_idx_next;
    logic                       ld_valid_reg, ld_valid_next;
    logic [EAW-1:0]             ld_e_reg;
    logic [VW-1:0]              ld_from_reg, ld_to_reg;
    logic                       res_valid_reg, res_valid_next;
    logic                       res_cycle_reg, res_cycle_next;
    logic                       res_drop_reg, res_drop_next;

    dcd_pkg::mem_ctl_t          ctl;
    logic [VW-1:0]              hd_raddr, hd_waddr;
    logic [EW-1:0]              hd_wdata, hd_rdata;
    logic [VW-1:0]              col_raddr, col_waddr;
    dcd_pkg::color_t            col_wdata, col_rdata;
    logic [EAW-1:0]             edg_raddr;
    logic [VW-1:0]              edg_rtgt;
    logic [EW-1:0]              edg_rnext;
    logic [VW-1:0]              stk_raddr, stk_waddr;
    logic [VW-1:0]              stk_rvert;
    logic [EW-1:0]              stk_redge;

    logic                       accept;
    logic [NW-1:0]              vc_ext, n_eff, from_ext, to_ext, from_m1, to_m1;
    logic                       edge_ok;
    logic                       e_empty, depth_one, scan_last, clr_done, res_go;
    logic [DW-1:0]              depth_m1, depth_m2;

    assign accept    = edges.valid && edges.ready;
    assign vc_ext    = NW'(vcount_reg);
    assign n_eff     = (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;
    assign from_ext  = NW'(edges.edge_from);
    assign to_ext    = NW'(edges.edge_to);
    assign from_m1   = from_ext - NW'(1);
    assign to_m1     = to_ext - NW'(1);
    assign edge_ok   = (from_ext != '0) && (from_ext <= n_eff) &&
                       (to_ext != '0) && (to_ext <= n_eff) && (ecnt_reg != EMPTY);
    assign e_empty   = (cur_e_reg == EMPTY);
    assign depth_one = (depth_reg == DW'(1));
    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);
    assign scan_last = (NW'(scan_v_reg) == n_eff - NW'(1));
    assign clr_done  = (clr_idx_reg == VW'(MAX_VERTICES - 1));
    assign res_go    = !res_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dcd_pkg::S_CLEAR:
                if (clr_done)
                    state_next = dcd_pkg::S_LOAD;
            dcd_pkg::S_LOAD:
                if (accept && edges.last_edge)
                    state_next = dcd_pkg::S_DRAIN;
            dcd_pkg::S_DRAIN:
                state_next = (n_eff == '0) ? dcd_pkg::S_RESULT : dcd_pkg::S_SCAN;
            dcd_pkg::S_SCAN:
                state_next = dcd_pkg::S_SCAN_CHK;
            dcd_pkg::S_SCAN_CHK:
                priority if (col_rdata == dcd_pkg::COL_WHITE)
                    state_next = dcd_pkg::S_STEP;
                else if (scan_last)
                    state_next = dcd_pkg::S_RESULT;
                else
                    state_next = dcd_pkg::S_SCAN;
            dcd_pkg::S_STEP:
                priority if (!e_empty)
                    state_next = dcd_pkg::S_EDGE;
                else if (!depth_one)
                    state_next = dcd_pkg::S_POP;
                else if (scan_last)
                    state_next = dcd_pkg::S_RESULT;
                else
                    state_next = dcd_pkg::S_SCAN;
            dcd_pkg::S_POP:
                state_next = dcd_pkg::S_STEP;
            dcd_pkg::S_EDGE:
                state_next = dcd_pkg::S_VISIT;
            dcd_pkg::S_VISIT:
                state_next = (col_rdata == dcd_pkg::COL_GREY) ? dcd_pkg::S_RESULT
                                                               : dcd_pkg::S_STEP;
            dcd_pkg::S_RESULT:
                if (res_go)
                    state_next = dcd_pkg::S_CLEAR;
            default:
                state_next = dcd_pkg::S_CLEAR;
        endcase
    end

    // memory requests and channel handshakes
    always_comb
    begin
        ctl       = '0;
        hd_raddr  = from_m1[VW-1:0];
        hd_waddr  = ld_from_reg;
        hd_wdata  = {1'b0, ld_e_reg};
        col_raddr = scan_v_reg;
        col_waddr = clr_idx_reg;
        col_wdata = dcd_pkg::COL_WHITE;
        edg_raddr = cur_e_reg[EAW-1:0];
        stk_raddr = depth_m2[VW-1:0];
        stk_waddr = depth_m1[VW-1:0];

        if (ld_valid_reg)
        begin
            ctl.hd_we  = 1'b1;
            ctl.edg_we = 1'b1;
        end

        unique case (state_reg)
            dcd_pkg::S_CLEAR:
            begin
                ctl.hd_we  = 1'b1;
                hd_waddr   = clr_idx_reg;
                hd_wdata   = EMPTY;
                ctl.col_we = 1'b1;
            end
            dcd_pkg::S_LOAD:
                ctl.hd_re = accept;
            dcd_pkg::S_SCAN:
            begin
                ctl.hd_re  = 1'b1;
                hd_raddr   = scan_v_reg;
                ctl.col_re = 1'b1;
            end
            dcd_pkg::S_SCAN_CHK:
                if (col_rdata == dcd_pkg::COL_WHITE)
                begin
                    ctl.col_we = 1'b1;
                    col_waddr  = scan_v_reg;
                    col_wdata  = dcd_pkg::COL_GREY;
                end
            dcd_pkg::S_STEP:
                if (!e_empty)
                    ctl.edg_re = 1'b1;
                else
                begin
                    ctl.col_we = 1'b1;
                    col_waddr  = cur_v_reg;
                    col_wdata  = dcd_pkg::COL_BLACK;
                    ctl.stk_re = !depth_one;
                end
            dcd_pkg::S_EDGE:
            begin
                ctl.hd_re  = 1'b1;
                hd_raddr   = edg_rtgt;
                ctl.col_re = 1'b1;
                col_raddr  = edg_rtgt;
            end
            dcd_pkg::S_VISIT:
                if (col_rdata == dcd_pkg::COL_WHITE)
                begin
                    ctl.col_we = 1'b1;
                    col_waddr  = w_reg;
                    col_wdata  = dcd_pkg::COL_GREY;
                    ctl.stk_we = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    assign edges.ready     = (state_reg == dcd_pkg::S_LOAD);
    assign cfg.ready       = 1'b1;
    assign result.valid    = res_valid_reg;
    assign result.has_cycle     = res_cycle_reg;
    assign result.edges_dropped = res_drop_reg;

    // datapath next values
    always_comb
    begin
        ecnt_next      = ecnt_reg;
        drop_next      = drop_reg;
        found_next     = found_reg;
        scan_v_next    = scan_v_reg;
        cur_v_next     = cur_v_reg;
        cur_e_next     = cur_e_reg;
        w_next         = w_reg;
        depth_next     = depth_reg;
        clr_idx_next   = clr_idx_reg;
        ld_valid_next  = accept && edges.edge_present && edge_ok;
        res_valid_next = res_valid_reg && !result.ready;
        res_cycle_next = res_cycle_reg;
        res_drop_next  = res_drop_reg;

        unique case (state_reg)
            dcd_pkg::S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + VW'(1);
                found_next   = 1'b0;
            end
            dcd_pkg::S_LOAD:
                if (accept && edges.edge_present)
                begin
                    if (edge_ok)
                        ecnt_next = ecnt_reg + EW'(1);
                    else
                        drop_next = 1'b1;
                end
            dcd_pkg::S_DRAIN:
                scan_v_next = '0;
            dcd_pkg::S_SCAN:
            begin
            end
            dcd_pkg::S_SCAN_CHK:
                if (col_rdata == dcd_pkg::COL_WHITE)
                begin
                    cur_v_next = scan_v_reg;
                    cur_e_next = hd_rdata;
                    depth_next = DW'(1);
                end
                else if (!scan_last)
                    scan_v_next = scan_v_reg + VW'(1);
            dcd_pkg::S_STEP:
                if (e_empty && depth_one && !scan_last)
                    scan_v_next = scan_v_reg + VW'(1);
            dcd_pkg::S_POP:
            begin
                cur_v_next = stk_rvert;
                cur_e_next = stk_redge;
                depth_next = depth_m1;
            end
            dcd_pkg::S_EDGE:
            begin
                cur_e_next = edg_rnext;
                w_next     = edg_rtgt;
            end
            dcd_pkg::S_VISIT:
                if (col_rdata == dcd_pkg::COL_GREY)
                    found_next = 1'b1;
                else if (col_rdata == dcd_pkg::COL_WHITE)
                begin
                    cur_v_next = w_reg;
                    cur_e_next = hd_rdata;
                    depth_next = depth_reg + DW'(1);
                end
            dcd_pkg::S_RESULT:
                if (res_go)
                begin
                    res_valid_next = 1'b1;
                    res_cycle_next = found_reg;
                    res_drop_next  = drop_reg;
                    ecnt_next      = '0;
                    drop_next      = 1'b0;
                    clr_idx_next   = '0;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcd_pkg::S_CLEAR;
            vcount_reg    <= dcd_pkg::VCOUNT_RESET;
            ecnt_reg      <= '0;
            drop_reg      <= 1'b0;
            found_reg     <= 1'b0;
            scan_v_reg    <= '0;
            depth_reg     <= '0;
            clr_idx_reg   <= '0;
            ld_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg.valid && cfg.ready)
                vcount_reg <= cfg.vertex_count;
            ecnt_reg      <= ecnt_next;
            drop_reg      <= drop_next;
            found_reg     <= found_next;
            scan_v_reg    <= scan_v_next;
            depth_reg     <= depth_next;
            clr_idx_reg   <= clr_idx_next;
            ld_valid_reg  <= ld_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_v_reg     <= cur_v_next;
        cur_e_reg     <= cur_e_next;
        w_reg         <= w_next;
        res_cycle_reg <= res_cycle_next;
        res_drop_reg  <= res_drop_next;
        if (accept)
        begin
            ld_e_reg    <= ecnt_reg[EAW-1:0];
            ld_from_reg <= from_m1[VW-1:0];
            ld_to_reg   <= to_m1[VW-1:0];
        end
    end

    dcd_graph_mem #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .hd_raddr  (hd_raddr),
        .hd_waddr  (hd_waddr),
        .hd_wdata  (hd_wdata),
        .hd_rdata  (hd_rdata),
        .col_raddr (col_raddr),
        .col_waddr (col_waddr),
        .col_wdata (col_wdata),
        .col_rdata (col_rdata),
        .edg_raddr (edg_raddr),
        .edg_waddr (ld_e_reg),
        .edg_wtgt  (ld_to_reg),
        .edg_wnext (hd_rdata),
        .edg_rtgt  (edg_rtgt),
        .edg_rnext (edg_rnext),
        .stk_raddr (stk_raddr),
        .stk_waddr (stk_waddr),
        .stk_wvert (cur_v_reg),
        .stk_wedge (cur_e_reg),
        .stk_rvert (stk_rvert),
        .stk_redge (stk_redge)
    );

    a_ecnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecnt_reg <= EMPTY)
        else $error("stored edge count beyond store size");

    a_depth_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcd_pkg::S_STEP || state_reg == dcd_pkg::S_EDGE ||
         state_reg == dcd_pkg::S_VISIT) |-> (depth_reg != '0))
        else $error("search step with empty stack");

    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcd_pkg::S_POP) |-> (depth_reg > DW'(1)))
        else $error("pop from the start vertex");

    a_load_window: assert property (@(posedge clk) disable iff (!rst_n)
        ld_valid_reg |-> (state_reg == dcd_pkg::S_LOAD || state_reg == dcd_pkg::S_DRAIN))
        else $error("edge link write outside load");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == dcd_pkg::S_RESULT))
        else $error("result raised outside result state");

endmodule
